### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the sparse multiply block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is switched off while reset is held.
`define CSR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also runs across reset.
`define CSR_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/csrspmv_pkg.sv
// ----------------------------------------------------------------------------
// csrspmv_pkg
// Types and constants shared by the sparse matrix vector multiply modules.
// ----------------------------------------------------------------------------
`default_nettype none

package csrspmv_pkg;

    localparam int unsigned IDX_W  = 10;
    localparam int unsigned VAL_W  = 32;
    localparam int unsigned VLEN_W = 11;
    localparam int unsigned ACC_W  = 64;

    localparam logic [VLEN_W-1:0] VLEN_RESET = 11'd1024;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_NZ    = 2'd1;
    localparam logic [1:0] MODE_EMPTY = 2'd2;

    localparam int unsigned FIFO_DEPTH = 8;
    localparam int unsigned FIFO_AW    = 3;
    localparam int unsigned PEND_W     = 2;

    // Item leaving the lookup stage.
    typedef struct packed {
        logic                    nz;     // in-range nonzero, multiply it
        logic                    bad;    // nonzero with out-of-range column
        logic                    last;   // nonzero ending its row
        logic                    empty;  // empty row
        logic signed [VAL_W-1:0] value;
        logic signed [VAL_W-1:0] entry;  // stored vector entry
    } t_lookup;

    // Finished row handed to the output stage.
    typedef struct packed {
        logic                    valid;
        logic signed [ACC_W-1:0] acc;
        logic                    sat;
        logic                    bad;
    } t_row;

endpackage

`default_nettype wire

### sv/csr_sparse_matrix_vector_multiply.sv
// ----------------------------------------------------------------------------
// csr_sparse_matrix_vector_multiply
// Sparse matrix times dense vector in compressed-row order, signed Q16.16.
// ----------------------------------------------------------------------------
// The block takes one item in every cycle while it has room: vector loads,
// nonzeros and empty rows stream in without gaps. A row result raises
// o_m_tvalid once the item that ends the row has passed the vector lookup,
// multiply and accumulate registers (with the clip in front of the queue)
// and has been written into the queue. The rate is set by the one read of
// the vector store and the one 32 by 32 multiply each item needs. Results
// wait in an eight-entry queue; the input stalls only when that queue and
// the rows still in flight would fill it. The vector store has no reset, so
// every entry a nonzero can reach must be loaded first. The length register
// must be written while the block is idle; the block does not check this.
`default_nettype none

module csr_sparse_matrix_vector_multiply
    import csrspmv_pkg::*;
#(
    parameter int unsigned VECTOR_DEPTH = 1024
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire [VLEN_W-1:0]    i_cfg_wdata,   // vector_length
    input  wire                 i_s_tvalid,
    output logic                o_s_tready,
    input  wire [47:0]          i_s_tdata,     // [1:0] mode, [11:2] index, [43:12] value
    input  wire                 i_s_tlast,     // row_end
    output logic                o_m_tvalid,
    input  wire                 i_m_tready,
    output logic [VAL_W-1:0]    o_m_tdata,     // [31:0] row_sum
    output logic [1:0]          o_m_tuser      // [0] saturated, [1] bad_column
);

    t_lookup           lk_item;
    t_row              mac_row;
    logic              lk_pend;
    logic              mac_pend;
    logic              room;
    logic              accept;
    logic [PEND_W-1:0] pend;

    assign o_s_tready = room;
    assign accept     = i_s_tvalid && room;
    assign pend       = PEND_W'(lk_pend) + PEND_W'(mac_pend);

    csrspmv_lookup #(
        .VECTOR_DEPTH (VECTOR_DEPTH)
    ) u_lookup (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_mode      (i_s_tdata[1:0]),
        .i_index     (i_s_tdata[11:2]),
        .i_value     (i_s_tdata[43:12]),
        .i_row_end   (i_s_tlast),
        .o_item      (lk_item),
        .o_pend      (lk_pend)
    );

    csrspmv_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (lk_item),
        .o_row   (mac_row),
        .o_pend  (mac_pend)
    );

    csrspmv_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_row      (mac_row),
        .i_pend     (pend),
        .o_room     (room),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

`default_nettype wire

### sv/csrspmv_lookup.sv
// ----------------------------------------------------------------------------
// csrspmv_lookup
// Vector store, column range check and the length register.
// ----------------------------------------------------------------------------
`default_nettype none

module csrspmv_lookup
    import csrspmv_pkg::*;
#(
    parameter int unsigned VECTOR_DEPTH = 1024
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_we,
    input  wire [VLEN_W-1:0]        i_cfg_wdata,
    input  wire                     i_accept,
    input  wire [1:0]               i_mode,
    input  wire [IDX_W-1:0]         i_index,
    input  wire [VAL_W-1:0]         i_value,
    input  wire                     i_row_end,
    output t_lookup                 o_item,
    output logic                    o_pend
);

    localparam int unsigned AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

    logic [VAL_W-1:0]    r_mem [VECTOR_DEPTH];
    logic [VAL_W-1:0]    r_entry;
    logic [VAL_W-1:0]    r_value;
    logic                r_nz;
    logic                r_bad;
    logic                r_last;
    logic                r_empty;
    logic [VLEN_W-1:0]   r_vlen;

    logic [AW+IDX_W-1:0] idx_wide;
    logic [AW-1:0]       addr;
    logic                in_depth;
    logic                in_len;
    logic                is_nz;

    assign idx_wide = {{AW{1'b0}}, i_index};
    assign addr     = idx_wide[AW-1:0];
    assign in_depth = 32'(i_index) < 32'(VECTOR_DEPTH);
    assign in_len   = {1'b0, i_index} < r_vlen;
    assign is_nz    = i_accept && (i_mode == MODE_NZ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vlen <= VLEN_RESET;
        end else if (i_cfg_we) begin
            r_vlen <= i_cfg_wdata;
        end
    end

    // Single port: a load writes, a nonzero reads.
    always_ff @(posedge i_clk) begin
        if (i_accept && (i_mode == MODE_LOAD) && in_depth) begin
            r_mem[addr] <= i_value;
        end
        if (is_nz) begin
            r_entry <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nz    <= 1'b0;
            r_bad   <= 1'b0;
            r_last  <= 1'b0;
            r_empty <= 1'b0;
        end else begin
            r_nz    <= is_nz && in_depth && in_len;
            r_bad   <= is_nz && !(in_depth && in_len);
            r_last  <= is_nz && i_row_end;
            r_empty <= i_accept && (i_mode == MODE_EMPTY);
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= i_value;
    end

    always_comb begin
        o_item.nz    = r_nz;
        o_item.bad   = r_bad;
        o_item.last  = r_last;
        o_item.empty = r_empty;
        o_item.value = signed'(r_value);
        o_item.entry = signed'(r_entry);
    end

    assign o_pend = r_last || r_empty;

endmodule

`default_nettype wire

### sv/csrspmv_mac.sv
// ----------------------------------------------------------------------------
// csrspmv_mac
// Product register and the saturating row accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module csrspmv_mac
    import csrspmv_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire t_lookup i_item,
    output t_row       o_row,
    output logic       o_pend
);

    logic signed [ACC_W-1:0] r_prod;
    logic                    r_nz;
    logic                    r_bad;
    logic                    r_last;
    logic                    r_empty;

    logic signed [ACC_W-1:0] r_acc;
    logic                    r_sat;
    logic                    r_badcol;
    t_row                    r_fin;

    logic signed [ACC_W-1:0] p;
    logic        [ACC_W:0]   sum;
    logic signed [ACC_W-1:0] n_acc;
    logic                    n_sat;
    logic                    n_bad;

    always_ff @(posedge i_clk) begin
        r_prod <= i_item.value * i_item.entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nz    <= 1'b0;
            r_bad   <= 1'b0;
            r_last  <= 1'b0;
            r_empty <= 1'b0;
        end else begin
            r_nz    <= i_item.nz;
            r_bad   <= i_item.bad;
            r_last  <= i_item.last;
            r_empty <= i_item.empty;
        end
    end

    // Arithmetic shift rounds toward minus infinity, as the format requires.
    assign p   = r_prod >>> 16;
    assign sum = {r_acc[ACC_W-1], r_acc} + {p[ACC_W-1], p};

    always_comb begin
        n_acc = r_acc;
        n_sat = r_sat;
        n_bad = r_badcol || r_bad;
        if (r_nz) begin
            if (sum[ACC_W] != sum[ACC_W-1]) begin
                n_acc = p[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
                n_sat = 1'b1;
            end else begin
                n_acc = signed'(sum[ACC_W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_sat     <= 1'b0;
            r_badcol  <= 1'b0;
            r_fin     <= '0;
        end else begin
            r_fin.valid <= r_last || r_empty;
            // An empty row reports zeros and leaves a partial row alone.
            r_fin.acc   <= r_last ? n_acc : '0;
            r_fin.sat   <= r_last ? n_sat : 1'b0;
            r_fin.bad   <= r_last ? n_bad : 1'b0;
            if (r_last) begin
                r_acc    <= '0;
                r_sat    <= 1'b0;
                r_badcol <= 1'b0;
            end else begin
                r_acc    <= n_acc;
                r_sat    <= n_sat;
                r_badcol <= n_bad;
            end
        end
    end

    assign o_row  = r_fin;
    assign o_pend = r_last || r_empty;

endmodule

`default_nettype wire

### sv/csrspmv_out.sv
// ----------------------------------------------------------------------------
// csrspmv_out
// Clips the row sum to 32 bits and queues results for the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module csrspmv_out
    import csrspmv_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire t_row           i_row,
    input  wire [PEND_W-1:0]    i_pend,
    output logic                o_room,
    output logic                o_m_tvalid,
    input  wire                 i_m_tready,
    output logic [VAL_W-1:0]    o_m_tdata,   // row_sum
    output logic [1:0]          o_m_tuser    // [0] saturated, [1] bad_column
);

    logic [VAL_W+1:0]    r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wr;
    logic [FIFO_AW-1:0]  r_rd;
    logic [FIFO_AW:0]    r_count;

    logic                fits;
    logic [VAL_W-1:0]    clip;
    logic                pop;
    logic [FIFO_AW+1:0]  used;

    assign fits = (i_row.acc[ACC_W-1:VAL_W-1] == '0) || (i_row.acc[ACC_W-1:VAL_W-1] == '1);
    assign clip = fits ? i_row.acc[VAL_W-1:0]
                       : (i_row.acc[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
                                             : {1'b0, {(VAL_W-1){1'b1}}});

    assign pop = (r_count != '0) && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (i_row.valid) begin
            r_fifo[r_wr] <= {i_row.bad, i_row.sat || !fits, clip};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_row.valid) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + (FIFO_AW+1)'(i_row.valid) - (FIFO_AW+1)'(pop);
        end
    end

    // Every result still in the pipe already owns a queue slot.
    assign used   = (FIFO_AW+2)'(r_count) + (FIFO_AW+2)'(i_pend) + (FIFO_AW+2)'(i_row.valid);
    assign o_room = used < (FIFO_AW+2)'(FIFO_DEPTH);

    assign o_m_tvalid = r_count != '0;
    assign o_m_tdata  = r_fifo[r_rd][VAL_W-1:0];
    assign o_m_tuser  = r_fifo[r_rd][VAL_W+1:VAL_W];

endmodule

`default_nettype wire

### sv/csrspmv_checker.sv
// ----------------------------------------------------------------------------
// csrspmv_checker
// Port-level checks on the sparse matrix vector multiply block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module csrspmv_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_s_tready,
    input wire        o_m_tvalid,
    input wire        i_m_tready,
    input wire [31:0] o_m_tdata,
    input wire [1:0]  o_m_tuser
);

    // No result may be left over from before reset.
    `CSR_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> !o_m_tvalid, "result valid after reset")

    // The input only stalls when the result queue holds something.
    `CSR_ASSERT(a_stall_needs_backlog, i_clk, i_rst_n, !o_s_tready |-> o_m_tvalid, "input stalled with empty output")

    // A result that is not taken stays put.
    `CSR_ASSERT(a_hold_result, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "stalled result changed")

endmodule

bind csr_sparse_matrix_vector_multiply csrspmv_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire

### dv/csr_sparse_matrix_vector_multiply_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_sparse_matrix_vector_multiply_tb
// Self-checking bench for the compressed-row sparse matrix times vector block.
// A queue of items feeds a stream driver. A bit-exact copy of the row
// arithmetic predicts every row result. A monitor compares the output stream
// with them. Both stream sides stall in random bursts, but for the last run.
// Several vector lengths are used, from zero up to the full store.
// ----------------------------------------------------------------------------

module csr_sparse_matrix_vector_multiply_tb;
    import csrspmv_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int unsigned STORE_DEPTH = 1024;
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam logic signed [63:0] SUM_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SUM_MIN = -64'sd2147483648;

    typedef struct {
        logic [1:0]         mode;
        logic [IDX_W-1:0]   index;
        logic [VAL_W-1:0]   value;
        logic               row_end;
        bit                 hold;    // wait for all pending rows before sending
    } t_item;

    typedef struct {
        logic [VAL_W-1:0]   sum;
        logic               clipped;
        logic               bad_col;
    } t_row_sum;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [VLEN_W-1:0]   cfg_wdata = '0;
    logic                s_valid = 1'b0;
    logic [47:0]         s_data = '0;
    logic                s_last = 1'b0;
    logic                m_ready = 1'b0;
    wire                 o_s_tready;
    wire                 o_m_tvalid;
    wire [VAL_W-1:0]     o_m_tdata;
    wire [1:0]           o_m_tuser;

    csr_sparse_matrix_vector_multiply uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),   // vector_length
        .i_s_tvalid  (s_valid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_data),      // [1:0] mode, [11:2] index, [43:12] value
        .i_s_tlast   (s_last),      // row_end
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (o_m_tdata),   // [31:0] row_sum
        .o_m_tuser   (o_m_tuser)    // [0] saturated, [1] bad_column
    );

    always #5 i_clk = ~i_clk;

    // Stimulus and expectations.
    t_item    pending_items[$];
    t_row_sum expected_rows[$];
    int       errors = 0;
    bit       steady = 1'b0;       // no idling on either side
    bit       pause_next = 1'b0;

    // Generator view of the store, so that no unwritten entry is ever read.
    bit       loaded_cols[STORE_DEPTH];
    int       gen_len = 1024;

    // Predicted block state.
    logic [VAL_W-1:0]        vec_entries[STORE_DEPTH];
    logic signed [63:0]      row_acc = '0;
    logic                    row_clip = 1'b0;
    logic                    row_bad = 1'b0;
    logic [VLEN_W-1:0]       cols_in_use = VLEN_RESET;

    task automatic accumulate_item(input t_item it);
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] prod;
        logic signed [64:0] total;
        t_row_sum r;
        case (it.mode)
            MODE_LOAD: begin
                vec_entries[it.index] = it.value;
            end
            MODE_EMPTY: begin
                r.sum = '0;
                r.clipped = 1'b0;
                r.bad_col = 1'b0;
                expected_rows.push_back(r);
            end
            MODE_NZ: begin
                if ({1'b0, it.index} >= cols_in_use) begin
                    row_bad = 1'b1;
                end else begin
                    a = $signed(it.value);
                    b = $signed(vec_entries[it.index]);
                    prod = (a * b) >>> 16;
                    total = {row_acc[63], row_acc} + {prod[63], prod};
                    if (total[64] != total[63]) begin
                        row_acc = total[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
                        row_clip = 1'b1;
                    end else begin
                        row_acc = total[63:0];
                    end
                end
                if (it.row_end) begin
                    r.clipped = row_clip;
                    r.bad_col = row_bad;
                    if (row_acc > SUM_MAX) begin
                        r.sum = SUM_MAX[31:0];
                        r.clipped = 1'b1;
                    end else if (row_acc < SUM_MIN) begin
                        r.sum = SUM_MIN[31:0];
                        r.clipped = 1'b1;
                    end else begin
                        r.sum = row_acc[31:0];
                    end
                    expected_rows.push_back(r);
                    row_acc = '0;
                    row_clip = 1'b0;
                    row_bad = 1'b0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic queue_item(input logic [1:0] mode, input int idx,
                              input logic [31:0] value, input logic last);
        t_item it;
        it.mode = mode;
        it.index = idx[IDX_W-1:0];
        it.value = value;
        it.row_end = last;
        it.hold = pause_next;
        pause_next = 1'b0;
        if (mode == MODE_LOAD) loaded_cols[idx] = 1'b1;
        pending_items.push_back(it);
    endtask

    // Mixes the extremes, full-range words and moderate Q16.16 numbers.
    function automatic logic [31:0] pick_q16();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3: return $urandom;
            default: return $urandom_range(0, 32'h3F_FFFF) - 32'h20_0000;
        endcase
    endfunction

    task automatic queue_nonzero(input int col, input logic [31:0] value,
                                 input logic last);
        if (!loaded_cols[col]) queue_item(MODE_LOAD, col, pick_q16(), $urandom_range(0, 1));
        queue_item(MODE_NZ, col, value, last);
    endtask

    // Rows of random content, with some noise and rows that are left open.
    // The count is the least number of items queued, the loads it needs included.
    task automatic queue_random_rows(input int count);
        int base;
        int n;
        int col;
        base = pending_items.size();
        while (pending_items.size() - base < count) begin
            case ($urandom_range(0, 99)) inside
                [0:69]: begin
                    n = $urandom_range(1, 6);
                    for (int k = 0; k < n; k++) begin
                        if (gen_len < STORE_DEPTH && (gen_len == 0 || $urandom_range(0, 9) == 0))
                            col = $urandom_range(gen_len, STORE_DEPTH - 1);
                        else
                            col = $urandom_range(0, gen_len - 1);
                        queue_nonzero(col, pick_q16(), k == n - 1);
                    end
                end
                [70:79]: begin
                    queue_item(MODE_EMPTY, $urandom_range(0, 1023), $urandom, $urandom_range(0, 1));
                end
                [80:87]: begin
                    queue_item(MODE_LOAD, $urandom_range(0, 1023), pick_q16(), $urandom_range(0, 1));
                end
                [88:92]: begin
                    // Nonzero without row end: it runs on into the next row.
                    queue_nonzero($urandom_range(0, 1023), pick_q16(), 1'b0);
                end
                [93:96]: begin
                    queue_item(MODE_UNUSED, $urandom_range(0, 1023), $urandom, $urandom_range(0, 1));
                end
                default: pause_next = 1'b1;
            endcase
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk); while (pending_items.size() != 0 || s_valid);
        while (expected_rows.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_length(input int len);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= len[VLEN_W-1:0];
        @(posedge i_clk);
        cfg_we <= 1'b0;
        gen_len = len;
    endtask

    // Sender.
    t_item   cur_item;
    int      src_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (cfg_we) cols_in_use = cfg_wdata;
            if (s_valid && o_s_tready) accumulate_item(cur_item);
            if (!s_valid || o_s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() != 0 &&
                             !(pending_items[0].hold && expected_rows.size() != 0)) begin
                    cur_item = pending_items.pop_front();
                    s_data <= {4'b0, cur_item.value, cur_item.index, cur_item.mode};
                    s_last <= cur_item.row_end;
                    s_valid <= 1'b1;
                    if (!steady && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 8);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver and checker.
    int       sink_gap = 0;
    t_row_sum want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_ready) begin
                if (expected_rows.size() == 0) begin
                    $display("%0t: unexpected row result: actual sum %h flags %b",
                             $time, o_m_tdata, o_m_tuser);
                    errors++;
                end else begin
                    want = expected_rows.pop_front();
                    if (o_m_tdata !== want.sum) begin
                        $display("%0t: row_sum mismatch: expected %h, actual %h",
                                 $time, want.sum, o_m_tdata);
                        errors++;
                    end
                    if (o_m_tuser[0] !== want.clipped) begin
                        $display("%0t: saturated mismatch: expected %b, actual %b",
                                 $time, want.clipped, o_m_tuser[0]);
                        errors++;
                    end
                    if (o_m_tuser[1] !== want.bad_col) begin
                        $display("%0t: bad_column mismatch: expected %b, actual %b",
                                 $time, want.bad_col, o_m_tuser[1]);
                        errors++;
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!steady && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 8);
            end
        end
    end

    // Watchdog on cycles without any transfer.
    int quiet = 0;

    always @(posedge i_clk) begin
        if ((s_valid && o_s_tready) || (o_m_tvalid && m_ready) || cfg_we) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        // Full length after reset: extremes, clipping, rounding and odd modes.
        queue_item(MODE_LOAD, 0, 32'h7FFF_FFFF, 1'b0);
        queue_item(MODE_LOAD, 1023, 32'h8000_0000, 1'b0);
        queue_item(MODE_LOAD, 512, 32'h0001_0000, 1'b0);
        queue_item(MODE_LOAD, 1, 32'hFFFF_0000, 1'b1);
        queue_item(MODE_LOAD, 2, 32'h0000_0003, 1'b0);
        queue_nonzero(0, 32'h7FFF_FFFF, 1'b1);
        queue_nonzero(1023, 32'h8000_0000, 1'b1);
        queue_nonzero(0, 32'h8000_0000, 1'b1);
        queue_nonzero(512, 32'h0002_8000, 1'b0);
        // An empty row in the middle of an open row leaves it alone.
        queue_item(MODE_EMPTY, 7, 32'h1234_5678, 1'b1);
        queue_nonzero(1, 32'hFFFF_FFFF, 1'b1);
        queue_item(MODE_UNUSED, 3, 32'hFFFF_FFFF, 1'b1);
        queue_item(MODE_UNUSED, 0, 32'h0, 1'b0);
        // Small negative product: the shift must round toward minus infinity.
        queue_nonzero(2, 32'hFFFF_FFFF, 1'b1);
        queue_nonzero(1023, 32'h0000_0001, 1'b1);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_idle();

        // One column in use: higher columns are out of range.
        write_length(1);
        queue_nonzero(0, 32'h0001_0000, 1'b0);
        queue_nonzero(5, 32'h0001_0000, 1'b1);
        queue_nonzero(1023, 32'h7FFF_FFFF, 1'b1);
        wait_idle();

        // Zero length: every column is out of range.
        write_length(0);
        queue_nonzero(0, 32'h0001_0000, 1'b1);
        queue_item(MODE_EMPTY, 0, 32'h0, 1'b0);
        wait_idle();

        write_length(1024);
        pause_next = 1'b1;
        queue_random_rows(200);
        wait_idle();

        write_length($urandom_range(2, 1023));
        queue_random_rows(200);
        wait_idle();

        write_length($urandom_range(1, 64));
        queue_random_rows(200);
        wait_idle();

        write_length(1024);
        steady = 1'b1;
        queue_random_rows(200);
        wait_idle();

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/csrspmv_pkg.sv
sv/csrspmv_lookup.sv
sv/csrspmv_mac.sv
sv/csrspmv_out.sv
sv/csr_sparse_matrix_vector_multiply.sv
sv/csrspmv_checker.sv
dv/csr_sparse_matrix_vector_multiply_tb.sv
